FILE: rtl/mcr_pkg.sv
// Shared types and constants for the midpoint circle rasterizer.
`default_nettype none

package mcr_pkg;

   // Request operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   // Control register indexes
   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   localparam int CoordW  = 12;  // pixel coordinate width
   localparam int DimW    = 13;  // screen dimension width
   localparam int OffW    = 13;  // signed octant offset width
   localparam int PosW    = 14;  // signed point coordinate width
   localparam int DecW    = 16;  // signed decision variable width
   localparam int RadiusW = 11;
   localparam int ColorW  = 32;
   localparam int AddrW   = 24;
   localparam int OctW    = 3;

   localparam int MaxDimDefault = 4096;

   localparam logic [DimW-1:0] WidthReset  = 13'd1024;
   localparam logic [DimW-1:0] HeightReset = 13'd768;

   localparam logic [OctW-1:0] OctFirst = 3'd0;
   localparam logic [OctW-1:0] OctLast  = 3'd7;

   // Snapshot of one step: the eight points share these values
   typedef struct packed {
      logic [CoordW-1:0]        center_col;
      logic [CoordW-1:0]        center_row;
      logic signed [OffW-1:0]   off_x;
      logic signed [OffW-1:0]   off_y;
      logic [ColorW-1:0]        color;
      logic                     done;
   } job_type;

   // One plotted point
   typedef struct packed {
      logic                visible;
      logic [CoordW-1:0]   pixel_x;
      logic [CoordW-1:0]   pixel_y;
      logic [AddrW-1:0]    pixel_address;
      logic [ColorW-1:0]   color_out;
      logic                last_of_step;
      logic                circle_done;
   } point_type;

endpackage

`default_nettype wire

FILE: rtl/mcr_walker.sv
// Circle walker: centre, offsets and midpoint decision variable.
`default_nettype none

module mcr_walker (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      load_en,
   input  wire logic                      step_en,
   input  wire logic [mcr_pkg::CoordW-1:0]  center_x,
   input  wire logic [mcr_pkg::CoordW-1:0]  center_y,
   input  wire logic [mcr_pkg::RadiusW-1:0] radius,
   input  wire logic [mcr_pkg::ColorW-1:0]  pixel_color,
   output      logic                      active,
   output      mcr_pkg::job_type          job
);
   import mcr_pkg::*;

   logic [CoordW-1:0]       col_ff, col_in;
   logic [CoordW-1:0]       row_ff, row_in;
   logic [ColorW-1:0]       color_ff, color_in;
   logic signed [OffW-1:0]  x_ff, x_in;
   logic signed [OffW-1:0]  y_ff, y_in;
   logic signed [DecW-1:0]  d_ff, d_in;
   logic                    active_ff, active_in;

   logic                    done;
   logic signed [OffW-1:0]  x_next;
   logic signed [OffW-1:0]  y_dec;
   logic signed [DecW-1:0]  diff_w;
   logic signed [DecW-1:0]  x_next_w;

   // Current point set handed to the sequencer
   assign done = (y_ff < x_ff);
   assign job  = '{center_col: col_ff, center_row: row_ff, off_x: x_ff, off_y: y_ff,
                   color: color_ff, done: done};
   assign active = active_ff;

   // Midpoint update terms
   assign x_next   = x_ff + OffW'(1);
   assign y_dec    = y_ff - OffW'(1);
   assign diff_w   = DecW'(x_next) - DecW'(y_dec);
   assign x_next_w = DecW'(x_next);

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      color_in  = color_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      d_in      = d_ff;
      active_in = active_ff;
      if (load_en) begin
         col_in    = center_x;
         row_in    = center_y;
         color_in  = pixel_color;
         x_in      = '0;
         y_in      = OffW'(radius);
         d_in      = DecW'(3) - (DecW'(radius) <<< 1);
         active_in = 1'b1;
      end else if (step_en) begin
         if (done) begin
            active_in = 1'b0;
         end else begin
            x_in = x_next;
            if (d_ff > 0) begin
               y_in = y_dec;
               d_in = d_ff + (diff_w <<< 2) + DecW'(10);
            end else begin
               d_in = d_ff + (x_next_w <<< 2) + DecW'(6);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      col_ff   <= col_in;
      row_ff   <= row_in;
      color_ff <= color_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      d_ff     <= d_in;
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/mcr_point_unit.sv
// Octant point unit: mirror, clip and address one point of a step.
`default_nettype none

module mcr_point_unit #(
   parameter int MAX_DIM = mcr_pkg::MaxDimDefault
) (
   input  wire mcr_pkg::job_type             job,
   input  wire logic [mcr_pkg::OctW-1:0]     octant,
   input  wire logic [mcr_pkg::DimW-1:0]     screen_width,
   input  wire logic [mcr_pkg::DimW-1:0]     screen_height,
   output      mcr_pkg::point_type           point
);
   import mcr_pkg::*;

   localparam int CmpW = $clog2(MAX_DIM + 1) > DimW ? $clog2(MAX_DIM + 1) : DimW;
   localparam logic [CmpW-1:0] MaxDimC = CmpW'(MAX_DIM);

   logic [CmpW-1:0]         width_c;
   logic [CmpW-1:0]         width_eff_c;
   logic [DimW-1:0]         width_eff;
   logic signed [OffW-1:0]  off_a;
   logic signed [OffW-1:0]  off_b;
   logic signed [PosW-1:0]  step_a;
   logic signed [PosW-1:0]  step_b;
   logic signed [PosW-1:0]  pos_x;
   logic signed [PosW-1:0]  pos_y;
   logic [DimW-1:0]         col;
   logic [DimW-1:0]         row;
   logic                    vis;
   logic [2*DimW-1:0]       row_base;
   logic [2*DimW-1:0]       addr_full;

   // Width limited to the largest supported dimension
   assign width_c     = CmpW'(screen_width);
   assign width_eff_c = (width_c > MaxDimC) ? MaxDimC : width_c;
   assign width_eff   = width_eff_c[DimW-1:0];

   // Octant select: bit 2 swaps x/y, bit 0 negates column, bit 1 negates row
   assign off_a  = octant[2] ? job.off_y : job.off_x;
   assign off_b  = octant[2] ? job.off_x : job.off_y;
   assign step_a = octant[0] ? -PosW'(off_a) : PosW'(off_a);
   assign step_b = octant[1] ? -PosW'(off_b) : PosW'(off_b);
   assign pos_x  = signed'(PosW'(job.center_col)) + step_a;
   assign pos_y  = signed'(PosW'(job.center_row)) + step_b;

   // Clip against the screen
   assign col = pos_x[DimW-1:0];
   assign row = pos_y[DimW-1:0];
   assign vis = !pos_x[PosW-1] && !pos_y[PosW-1] && (col < width_eff) && (row < screen_height);

   // Framebuffer word address
   assign row_base  = (2*DimW)'(row) * (2*DimW)'(width_eff);
   assign addr_full = row_base + (2*DimW)'(col);

   always_comb begin
      point.visible       = vis;
      point.pixel_x       = vis ? col[CoordW-1:0] : '0;
      point.pixel_y       = vis ? row[CoordW-1:0] : '0;
      point.pixel_address = vis ? addr_full[AddrW-1:0] : '0;
      point.color_out     = vis ? job.color : '0;
      point.last_of_step  = (octant == OctLast);
      point.circle_done   = job.done;
   end

endmodule

`default_nettype wire

FILE: rtl/midpoint_circle_rasterizer_top.sv
// Top level of the midpoint circle rasterizer with screen clipping.
//
//  Channel  Direction  Handshake            Payload
//  req      in         req_valid/req_ready  op, center, radius, color
//  rsp      out        rsp_valid/rsp_ready  eight plotted points per step request
//  csr      in         csr_write_enable     screen width / height
//
// A load request gives no result. A step request holds the octant sequencer for
// its eight octants, one point a cycle into the result register while rsp_ready
// does not stall it; the next request is taken at the edge that moves the eighth
// point into the result register. A stalled rsp_ready freezes the sequencer.
// Reset restores the screen size, clears the active circle and empties the pipe.
`default_nettype none

module midpoint_circle_rasterizer_top #(
   parameter int MAX_DIM = mcr_pkg::MaxDimDefault
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic                          req_op,
   input  wire logic [mcr_pkg::CoordW-1:0]    req_center_x,
   input  wire logic [mcr_pkg::CoordW-1:0]    req_center_y,
   input  wire logic [mcr_pkg::RadiusW-1:0]   req_radius,
   input  wire logic [mcr_pkg::ColorW-1:0]    req_pixel_color,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic                          rsp_visible,
   output      logic [mcr_pkg::CoordW-1:0]    rsp_pixel_x,
   output      logic [mcr_pkg::CoordW-1:0]    rsp_pixel_y,
   output      logic [mcr_pkg::AddrW-1:0]     rsp_pixel_address,
   output      logic [mcr_pkg::ColorW-1:0]    rsp_color_out,
   output      logic                          rsp_last_of_step,
   output      logic                          rsp_circle_done,
   input  wire logic                          csr_write_enable,
   input  wire logic                          csr_index,
   input  wire logic [mcr_pkg::DimW-1:0]      csr_write_data
);
   import mcr_pkg::*;

   logic [DimW-1:0]  width_ff, width_in;
   logic [DimW-1:0]  height_ff, height_in;
   job_type          job_ff, job_in;
   logic             job_valid_ff, job_valid_in;
   logic [OctW-1:0]  oct_ff, oct_in;
   point_type        rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             accept;
   logic             load_en;
   logic             step_en;
   logic             active;
   logic             advance;
   logic             job_free;
   job_type          job_now;
   point_type        point;

   // Handshake
   assign advance   = job_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign job_free  = !job_valid_ff || (advance && (oct_ff == OctLast));
   assign req_ready = job_free;
   assign accept    = req_valid && req_ready;
   assign load_en   = accept && (req_op == OP_LOAD);
   assign step_en   = accept && (req_op == OP_STEP) && active;

   mcr_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .load_en     (load_en),
      .step_en     (step_en),
      .center_x    (req_center_x),
      .center_y    (req_center_y),
      .radius      (req_radius),
      .pixel_color (req_pixel_color),
      .active      (active),
      .job         (job_now)
   );

   mcr_point_unit #(
      .MAX_DIM (MAX_DIM)
   ) u_point_unit (
      .job           (job_ff),
      .octant        (oct_ff),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .point         (point)
   );

   // Control registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  width_in  = csr_write_data;
            CSR_SCREEN_HEIGHT: height_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // Octant sequencer
   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      oct_in       = oct_ff;
      if (advance) begin
         oct_in = oct_ff + OctW'(1);
         if (oct_ff == OctLast) begin
            job_valid_in = 1'b0;
         end
      end
      if (step_en) begin
         job_in       = job_now;
         job_valid_in = 1'b1;
         oct_in       = OctFirst;
      end
   end

   // Result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_in       = point;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      oct_ff <= oct_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         width_ff     <= WidthReset;
         height_ff    <= HeightReset;
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         job_valid_ff <= job_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_visible       = rsp_ff.visible;
   assign rsp_pixel_x       = rsp_ff.pixel_x;
   assign rsp_pixel_y       = rsp_ff.pixel_y;
   assign rsp_pixel_address = rsp_ff.pixel_address;
   assign rsp_color_out     = rsp_ff.color_out;
   assign rsp_last_of_step  = rsp_ff.last_of_step;
   assign rsp_circle_done   = rsp_ff.circle_done;

endmodule

`default_nettype wire
